// ===== hw/rtl/oaht_pkg.sv =====
// Shared types, codes and small helper functions of the open-addressing hash table.
`default_nettype none

package oaht_pkg;

    // Field widths
    localparam int KEY_W  = 32;
    localparam int SIZE_W = 5;
    localparam int MODE_W = 2;
    localparam int OP_W   = 2;
    localparam int POS_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Probe modes (the spare code probes linearly)
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd1;

    // Reset values of the configuration registers
    localparam logic [MODE_W-1:0] PROBE_MODE_RST = MODE_LINEAR;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd7;

    // Slot store control word
    typedef struct packed {
        logic rd;   // read used flag and key at the address
        logic wr;   // store key and mark the slot used
        logic clr;  // free every slot
    } t_slot_op;

    // (a + b) mod m for a, b < m
    function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b,
                                                  input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m}) begin
            sum = sum - {1'b0, m};
        end
        return sum[SIZE_W-1:0];
    endfunction

    // 5 mod m for m >= 1
    function automatic logic [SIZE_W-1:0] five_mod(input logic [SIZE_W-1:0] m);
        logic [SIZE_W-1:0] res;
        case (m)
            5'd1:    res = 5'd0;
            5'd2:    res = 5'd1;
            5'd3:    res = 5'd2;
            5'd4:    res = 5'd1;
            5'd5:    res = 5'd0;
            default: res = 5'd5;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/open_addressing_hash_table.sv =====
// Top level of the open-addressing hash table: sequencer, configuration and result port.
//
// Raise start with an opcode and key while busy is low. Clear and the unused
// opcode answer in the next cycle. Insert and search first take the key's
// remainder by the table size in a bit-serial unit, then set up the probe,
// then probe slots in turn (a read of the slot store, then a check), at most
// m probes, where m is the table size in use (zero counts as one, larger
// values stop at TABLE_DEPTH). The result appears for exactly one cycle with
// o_done and cannot be held off, so take it when o_done is high. The
// configuration port is ready only while the block is idle and start is low.
`default_nettype none

module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [OP_W-1:0]       i_opcode,
    input  wire logic signed [KEY_W-1:0] i_key,
    output logic                       o_done,
    output logic                       o_status,
    output logic [POS_W-1:0]           o_position,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // only slots below the largest usable size are ever reached
    localparam int MAX_M  = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
    localparam int SLOT_W = $clog2(MAX_M);
    localparam logic [SIZE_W-1:0] MAX_M_S = SIZE_W'(MAX_M);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_INIT,
        ST_PROBE,
        ST_CHECK
    } t_state;

    t_state            r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [SIZE_W-1:0] r_size;
    logic [OP_W-1:0]   r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic              r_neg, n_neg;
    logic [SIZE_W-1:0] r_m, n_m;
    logic [SIZE_W-1:0] r_slot, n_slot;
    logic [SIZE_W-1:0] r_step, n_step;
    logic [SIZE_W-1:0] r_i, n_i;
    logic              r_done, n_done;
    logic              r_status, n_status;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic              accept;
    logic [SIZE_W-1:0] m_eff;
    logic [KEY_W-1:0]  key_mag;
    logic              rem_start;
    logic              rem_done;
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] c5;
    logic [SIZE_W-1:0] g;
    logic [SIZE_W-1:0] two_m;
    logic [SIZE_W-1:0] last_i;
    t_slot_op          slot_op;
    logic              slot_used;
    logic [KEY_W-1:0]  slot_key;

    // configuration registers, taken only between items
    assign o_cfg_ready = (r_state == ST_IDLE) && !start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PROBE_MODE_RST;
            r_size <= TABLE_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PROBE_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_TABLE_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // modulus in use: zero acts as one, saturate at the table depth
    always_comb begin
        if (r_size == '0) begin
            m_eff = SIZE_W'(1);
        end else if (r_size > MAX_M_S) begin
            m_eff = MAX_M_S;
        end else begin
            m_eff = r_size;
        end
    end

    assign accept  = start && (r_state == ST_IDLE);
    assign key_mag = i_key[KEY_W-1] ? (~i_key + 1'b1) : i_key;
    assign rem_start = accept && ((i_opcode == OP_INSERT) || (i_opcode == OP_SEARCH));

    oaht_urem u_urem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (key_mag),
        .i_divisor  (m_eff),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    // base hash, non-negative remainder
    assign h = (r_neg && (rem != '0)) ? (r_m - rem) : rem;

    // double-hash step (5 - h) mod m, with h held in r_slot
    assign c5 = five_mod(r_m);
    always_comb begin
        if (c5 >= r_slot) begin
            g = c5 - r_slot;
        end else begin
            g = SIZE_W'({1'b0, c5} + {1'b0, r_m} - {1'b0, r_slot});
        end
    end

    // quadratic step grows by 2 mod m
    assign two_m  = (r_m <= SIZE_W'(2)) ? '0 : SIZE_W'(2);
    assign last_i = r_m - 1'b1;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_neg    = r_neg;
        n_m      = r_m;
        n_slot   = r_slot;
        n_step   = r_step;
        n_i      = r_i;
        n_done   = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;
        slot_op  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op  = i_opcode;
                    n_key = i_key;
                    n_neg = i_key[KEY_W-1];
                    n_m   = m_eff;
                    unique case (i_opcode) inside
                        OP_CLEAR: begin
                            slot_op.clr = 1'b1;
                            n_done   = 1'b1;
                            n_status = 1'b0;
                            n_pos    = '0;
                        end
                        OP_INSERT, OP_SEARCH: begin
                            n_state = ST_REM;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = 1'b1;
                            n_pos    = '0;
                        end
                    endcase
                end
            end
            ST_REM: begin
                if (rem_done) begin
                    n_slot  = h;
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_i = '0;
                case (r_mode)
                    MODE_QUAD:   n_step = two_m;
                    MODE_DOUBLE: n_step = g;
                    default:     n_step = (r_m == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                endcase
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                slot_op.rd = 1'b1;
                n_state    = ST_CHECK;
            end
            ST_CHECK: begin
                if (!slot_used) begin
                    // free slot ends both insert and search
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_op == OP_INSERT) begin
                        slot_op.wr = 1'b1;
                        n_status   = 1'b0;
                        n_pos      = r_slot[POS_W-1:0];
                    end else begin
                        n_status = 1'b1;
                        n_pos    = '0;
                    end
                end else if ((r_op == OP_SEARCH) && (slot_key == r_key)) begin
                    n_done   = 1'b1;
                    n_state  = ST_IDLE;
                    n_status = 1'b0;
                    n_pos    = r_slot[POS_W-1:0];
                end else if (r_i == last_i) begin
                    // every probe used up: full or not found
                    n_done   = 1'b1;
                    n_state  = ST_IDLE;
                    n_status = 1'b1;
                    n_pos    = '0;
                end else begin
                    n_i    = r_i + 1'b1;
                    n_slot = mod_add(r_slot, r_step, r_m);
                    if (r_mode == MODE_QUAD) begin
                        n_step = mod_add(r_step, two_m, r_m);
                    end
                    n_state = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_neg    <= n_neg;
        r_m      <= n_m;
        r_slot   <= n_slot;
        r_step   <= n_step;
        r_i      <= n_i;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    oaht_slots #(
        .DEPTH (MAX_M)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (slot_op),
        .i_addr  (r_slot[SLOT_W-1:0]),
        .i_key   (r_key),
        .o_used  (slot_used),
        .o_key   (slot_key)
    );

    assign busy       = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_position = r_pos;

endmodule

`default_nettype wire

// ===== hw/rtl/oaht_urem.sv =====
// Bit-serial unsigned remainder of a 32-bit magnitude by the table size.
`default_nettype none

module oaht_urem
    import oaht_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [KEY_W-1:0]  i_dividend,
    input  wire logic [SIZE_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [SIZE_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(KEY_W);

    logic [KEY_W-1:0]  r_dvd;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   n_rem;

    // one dividend bit per cycle, restoring step
    always_comb begin
        trial = {r_rem, r_dvd[KEY_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_W-2:0], 1'b0};
            r_rem <= n_rem[SIZE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/oaht_slots.sv =====
// Slot store: key memory with registered read and per-slot used flags.
`default_nettype none

module oaht_slots
    import oaht_pkg::*;
#(
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_slot_op         i_op,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_used,
    output logic [KEY_W-1:0]      o_key
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_used;
    logic             r_used_rd;
    logic [KEY_W-1:0] r_key_rd;

    // used flags, freed by reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_op.clr) begin
            r_used <= '0;
        end else if (i_op.wr) begin
            r_used[i_addr] <= 1'b1;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_op.rd) begin
            r_used_rd <= r_used[i_addr];
            r_key_rd  <= mem[i_addr];
        end
    end

    // key memory write port
    always_ff @(posedge i_clk) begin
        if (i_op.wr) begin
            mem[i_addr] <= i_key;
        end
    end

    assign o_used = r_used_rd;
    assign o_key  = r_key_rd;

endmodule

`default_nettype wire
